@@ sv/ywc_pkg.sv @@
// ywc_pkg: shared types, codes, register defaults and twiddle generator
// for the yaw wiggle classifier. No dependencies.

package ywc_pkg;

  localparam int unsigned WINDOW_SIZE_DEF  = 64;
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;

  localparam int unsigned YAW_W      = 32;
  localparam int unsigned COND_W     = 2;
  localparam int unsigned LOUD_W     = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // twiddles are q1.15 with room for +1.0
  localparam int unsigned TW_W    = 17;
  localparam int unsigned TW_FRAC = 15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AMP_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STD_WIGGLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STD_FAST   = 3'd4;

  // register reset values
  localparam logic [31:0]        AMP_THR_RST    = 32'd65536;
  localparam logic [5:0]         BIN_LIMIT_RST  = 6'd10;
  localparam logic signed [31:0] MEAN_LIMIT_RST = 32'sd65536;
  localparam logic [30:0]        STD_WIGGLE_RST = 31'd196608;
  localparam logic [30:0]        STD_FAST_RST   = 31'd327680;

  // classes
  typedef logic [COND_W-1:0] cond_t;
  localparam cond_t COND_NORMAL   = 2'd0;
  localparam cond_t COND_WIGGLE   = 2'd1;
  localparam cond_t COND_FAST     = 2'd2;
  localparam cond_t COND_ABNORMAL = 2'd3;

  // serial multiplier jobs; the setup chain runs OP_TN up to OP_LFN in order
  typedef logic [3:0] mul_op_t;
  localparam mul_op_t OP_TN   = 4'd0;  // threshold * n
  localparam mul_op_t OP_TN2  = 4'd1;  // (threshold * n)^2 -> bin limit
  localparam mul_op_t OP_SQN  = 4'd2;  // n * sum of squares
  localparam mul_op_t OP_SUM2 = 4'd3;  // sum^2 -> spread
  localparam mul_op_t OP_LW2  = 4'd4;  // wiggle limit squared
  localparam mul_op_t OP_LWN  = 4'd5;  // times n(n-1), compare
  localparam mul_op_t OP_LF2  = 4'd6;  // fast limit squared
  localparam mul_op_t OP_LFN  = 4'd7;  // times n(n-1), compare
  localparam mul_op_t OP_RE2  = 4'd8;  // re^2
  localparam mul_op_t OP_IM2  = 4'd9;  // im^2
  localparam mul_op_t OP_SQX  = 4'd10; // sample squared

  typedef struct packed {
    logic    take;       // input beat taken, write sample
    logic    clr_stats;  // clear sum, sum of squares, loud count
    logic    rd;         // read window entry and twiddles
    logic    acc_stat;   // sum += sample
    logic    clr_bin;    // clear re / im
    logic    dft_mul;    // sample times twiddles
    logic    dft_acc;    // accumulate products
    logic    bin_cmp;    // compare bin power, count
    logic    mul_start;  // launch serial multiply
    mul_op_t mul_op;
    logic    res_load;   // load result register
  } ywc_cmd_t;

  typedef struct packed {
    logic full;
    logic mul_fin;
    logic res_free;
  } ywc_stat_t;

  // ceil(2^42 / d) for the taylor divisors; multiply and shift gives the
  // exact floor quotient for any term below 2^33
  localparam int unsigned RCP_SH  = 42;
  localparam logic [63:0] RCP_ONE = 64'd1 << RCP_SH;
  localparam logic [63:0] RCP_SIN [8] = '{
    (RCP_ONE + 64'd5) / 64'd6,     (RCP_ONE + 64'd19) / 64'd20,
    (RCP_ONE + 64'd41) / 64'd42,   (RCP_ONE + 64'd71) / 64'd72,
    (RCP_ONE + 64'd109) / 64'd110, (RCP_ONE + 64'd155) / 64'd156,
    (RCP_ONE + 64'd209) / 64'd210, (RCP_ONE + 64'd271) / 64'd272
  };
  localparam logic [63:0] RCP_COS [8] = '{
    (RCP_ONE + 64'd1) / 64'd2,     (RCP_ONE + 64'd11) / 64'd12,
    (RCP_ONE + 64'd29) / 64'd30,   (RCP_ONE + 64'd55) / 64'd56,
    (RCP_ONE + 64'd89) / 64'd90,   (RCP_ONE + 64'd131) / 64'd132,
    (RCP_ONE + 64'd181) / 64'd182, (RCP_ONE + 64'd239) / 64'd240
  };

  // q1.15 twiddle from a 32 bit phase, taylor series in q30, quadrant rotate
  function automatic logic signed [TW_W-1:0] twiddle(input longint unsigned ph,
                                                     input logic want_sin);
    longint unsigned q;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned ts;
    longint unsigned tc;
    longint          s;
    longint          c;
    longint          v;
    longint          a;
    logic [127:0]    wide;
    q  = (ph >> 30) & 64'd3;
    x  = ((ph & 64'h3FFF_FFFF) * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    s  = longint'(ts);
    c  = longint'(tc);
    for (int j = 1; j <= 8; j++) begin
      wide = 128'((ts * x2) >> 30) * 128'(RCP_SIN[j-1]);
      ts   = 64'(wide >> RCP_SH);
      wide = 128'((tc * x2) >> 30) * 128'(RCP_COS[j-1]);
      tc   = 64'(wide >> RCP_SH);
      if ((j & 1) == 1) begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end else begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end
    end
    case (q)
      64'd0:   v = want_sin ? s : c;
      64'd1:   v = want_sin ? c : -s;
      64'd2:   v = want_sin ? -s : -c;
      default: v = want_sin ? -c : s;
    endcase
    a = ((v < 0 ? -v : v) + 64'sd16384) >>> 15;
    return TW_W'(v < 0 ? -a : a);
  endfunction

endpackage

@@ sv/ywc_in_if.sv @@
// ywc_in_if: sample channel, valid/ready with one yaw sample per beat
// depends on ywc_pkg

interface ywc_in_if import ywc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [YAW_W-1:0] yaw_sample;

  modport source(output valid, output yaw_sample, input ready);
  modport sink(input valid, input yaw_sample, output ready);
endinterface

@@ sv/ywc_out_if.sv @@
// ywc_out_if: result channel, valid/ready with one class per beat
// depends on ywc_pkg

interface ywc_out_if import ywc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COND_W-1:0] condition;
  logic              window_full;
  logic [LOUD_W-1:0] loud_bins;

  modport source(output valid, output condition, output window_full, output loud_bins,
                 input ready);
  modport sink(input valid, input condition, input window_full, input loud_bins,
               output ready);
endinterface

@@ sv/ywc_mul.sv @@
// ywc_mul: shift-add unsigned multiplier, one multiplier bit per cycle
// depends on nothing

module ywc_mul #(
  parameter int unsigned A_W = 80,
  parameter int unsigned B_W = 40,
  localparam int unsigned CNT_W = $clog2(B_W + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic           fin,
  output logic [A_W-1:0] p
);

  logic [A_W-1:0]   a_q;
  logic [B_W-1:0]   b_q;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(B_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          fin <= 1'b1;
        end
      end
    end
  end

  // msb first: product doubles, then adds the multiplicand on a one bit
  always_ff @(posedge clk) begin
    if (start) begin
      p   <= '0;
      a_q <= a;
      b_q <= b;
    end else if (cnt != '0) begin
      p   <= {p[A_W-2:0], 1'b0} + (b_q[B_W-1] ? a_q : '0);
      b_q <= {b_q[B_W-2:0], 1'b0};
    end
  end

endmodule

@@ sv/ywc_ctrl.sv @@
// ywc_ctrl: sequencer for window statistics, setup products and the dft
// depends on ywc_pkg

module ywc_ctrl import ywc_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = WINDOW_SIZE_DEF,
  localparam int unsigned AW = $clog2(WINDOW_SIZE)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output ywc_cmd_t      cmd,
  input  ywc_stat_t     stat,
  output logic [AW-1:0] n_sel,
  output logic [AW-1:0] tw_idx
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_CHECK  = 5'd1;
  localparam logic [4:0] ST_S_RD   = 5'd2;
  localparam logic [4:0] ST_S_SQ   = 5'd3;
  localparam logic [4:0] ST_S_W    = 5'd4;
  localparam logic [4:0] ST_CH_GO  = 5'd5;
  localparam logic [4:0] ST_CH_W   = 5'd6;
  localparam logic [4:0] ST_D_INIT = 5'd7;
  localparam logic [4:0] ST_D_RD   = 5'd8;
  localparam logic [4:0] ST_D_MUL  = 5'd9;
  localparam logic [4:0] ST_D_ACC  = 5'd10;
  localparam logic [4:0] ST_B_RE   = 5'd11;
  localparam logic [4:0] ST_B_REW  = 5'd12;
  localparam logic [4:0] ST_B_IM   = 5'd13;
  localparam logic [4:0] ST_B_IMW  = 5'd14;
  localparam logic [4:0] ST_B_CMP  = 5'd15;
  localparam logic [4:0] ST_DONE   = 5'd16;

  localparam logic [AW-1:0] LAST    = AW'(WINDOW_SIZE - 1);
  localparam logic [AW-1:0] K_FIRST = AW'(WINDOW_SIZE / 2 + 1);
  localparam logic [AW:0]   N_EXT   = (AW + 1)'(WINDOW_SIZE);

  logic [4:0]    state, state_next;
  logic [AW-1:0] n, n_next;
  logic [AW-1:0] k, k_next;
  logic [AW-1:0] idx, idx_next;
  mul_op_t       op, op_next;
  logic [AW:0]   idx_sum;

  assign n_sel  = n;
  assign tw_idx = idx;

  // n*k mod N kept as a running index
  assign idx_sum = {1'b0, idx} + {1'b0, k};

  always_comb begin
    state_next = state;
    n_next     = n;
    k_next     = k;
    idx_next   = idx;
    op_next    = op;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.full) begin
          cmd.clr_stats = 1'b1;
          n_next        = '0;
          state_next    = ST_S_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_S_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_S_SQ;
      end
      ST_S_SQ: begin
        cmd.acc_stat  = 1'b1;
        cmd.mul_start = 1'b1;
        cmd.mul_op    = OP_SQX;
        state_next    = ST_S_W;
      end
      ST_S_W: begin
        if (stat.mul_fin) begin
          if (n == LAST) begin
            op_next    = OP_TN;
            state_next = ST_CH_GO;
          end else begin
            n_next     = n + 1'b1;
            state_next = ST_S_RD;
          end
        end
      end
      ST_CH_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = op;
        state_next    = ST_CH_W;
      end
      ST_CH_W: begin
        if (stat.mul_fin) begin
          if (op == OP_LFN) begin
            k_next     = K_FIRST;
            state_next = ST_D_INIT;
          end else begin
            op_next    = op + 1'b1;
            state_next = ST_CH_GO;
          end
        end
      end
      ST_D_INIT: begin
        cmd.clr_bin = 1'b1;
        n_next      = '0;
        idx_next    = '0;
        state_next  = ST_D_RD;
      end
      ST_D_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_D_MUL;
      end
      ST_D_MUL: begin
        cmd.dft_mul = 1'b1;
        state_next  = ST_D_ACC;
      end
      ST_D_ACC: begin
        cmd.dft_acc = 1'b1;
        idx_next    = (idx_sum >= N_EXT) ? AW'(idx_sum - N_EXT) : idx_sum[AW-1:0];
        if (n == LAST) begin
          state_next = ST_B_RE;
        end else begin
          n_next     = n + 1'b1;
          state_next = ST_D_RD;
        end
      end
      ST_B_RE: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = OP_RE2;
        state_next    = ST_B_REW;
      end
      ST_B_REW: begin
        if (stat.mul_fin) begin
          state_next = ST_B_IM;
        end
      end
      ST_B_IM: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = OP_IM2;
        state_next    = ST_B_IMW;
      end
      ST_B_IMW: begin
        if (stat.mul_fin) begin
          state_next = ST_B_CMP;
        end
      end
      ST_B_CMP: begin
        cmd.bin_cmp = 1'b1;
        if (k == LAST) begin
          state_next = ST_DONE;
        end else begin
          k_next     = k + 1'b1;
          state_next = ST_D_INIT;
        end
      end
      ST_DONE: begin
        if (stat.res_free) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n     <= '0;
      k     <= '0;
      idx   <= '0;
      op    <= OP_TN;
    end else begin
      state <= state_next;
      n     <= n_next;
      k     <= k_next;
      idx   <= idx_next;
      op    <= op_next;
    end
  end

endmodule

@@ sv/ywc_dp.sv @@
// ywc_dp: sample window memory, config registers, statistics, dft
// accumulators, shared serial multiplier and result register
// depends on ywc_pkg, ywc_mul

module ywc_dp import ywc_pkg::*; #(
  parameter int unsigned WINDOW_SIZE  = WINDOW_SIZE_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int unsigned AW = $clog2(WINDOW_SIZE)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ywc_cmd_t                cmd,
  output ywc_stat_t               stat,
  input  logic [AW-1:0]           n_sel,
  input  logic [AW-1:0]           tw_idx,
  input  logic signed [YAW_W-1:0] yaw_sample,
  input  logic                    wr_en,
  input  logic [CFG_IDX_W-1:0]    wr_index,
  input  logic [CFG_DATA_W-1:0]   wr_data,
  input  logic                    res_ready,
  output logic                    res_valid,
  output logic [COND_W-1:0]       condition,
  output logic                    window_full,
  output logic [LOUD_W-1:0]       loud_bins
);

  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned LN   = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned MXW  = (SW > 32) ? SW : 32;
  localparam int unsigned HW   = MXW + LN + 1;
  localparam int unsigned CW   = 2 * MXW + 2 * LN + 4;
  localparam int unsigned SUMW = SW + LN;
  localparam int unsigned SQW  = 2 * SW + LN;
  localparam int unsigned ACW  = SW + LN + 1;
  localparam int unsigned PRW  = SW + TW_W;
  localparam int unsigned LDW  = $clog2(WINDOW_SIZE / 2) + 1;
  localparam int unsigned LCW  = (LDW > LOUD_W) ? LDW : LOUD_W;
  localparam int unsigned MLW  = 33 + LN;
  localparam int unsigned XCW  = (SUMW > MLW) ? SUMW : MLW;

  localparam longint unsigned NN = longint'(WINDOW_SIZE) * longint'(WINDOW_SIZE - 1);
  localparam logic [AW:0]         N_EXT = (AW + 1)'(WINDOW_SIZE);
  localparam logic signed [MLW-1:0] N_S = MLW'(WINDOW_SIZE);

  // twiddle tables, fixed at elaboration
  logic signed [TW_W-1:0] tw_cos [WINDOW_SIZE];
  logic signed [TW_W-1:0] tw_sin [WINDOW_SIZE];

  for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_tw
    localparam longint unsigned PH = (longint'(g) << 32) / WINDOW_SIZE;
    localparam logic signed [TW_W-1:0] COS_V = twiddle(PH, 1'b0);
    localparam logic signed [TW_W-1:0] SIN_V = twiddle(PH, 1'b1);
    assign tw_cos[g] = COS_V;
    assign tw_sin[g] = SIN_V;
  end

  // config registers
  logic [31:0]        thr;
  logic [5:0]         bcl;
  logic signed [31:0] ml;
  logic [30:0]        lw;
  logic [30:0]        lf;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= AMP_THR_RST;
      bcl <= BIN_LIMIT_RST;
      ml  <= MEAN_LIMIT_RST;
      lw  <= STD_WIGGLE_RST;
      lf  <= STD_FAST_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_AMP_THR:    thr <= wr_data;
        REG_BIN_LIMIT:  bcl <= wr_data[5:0];
        REG_MEAN_LIMIT: ml  <= $signed(wr_data);
        REG_STD_WIGGLE: lw  <= wr_data[30:0];
        REG_STD_FAST:   lf  <= wr_data[30:0];
        default: ;
      endcase
    end
  end

  // window state
  logic [AW-1:0]        wp;
  logic [LN-1:0]        fill;
  logic [63:0]          yaw_ext;
  logic signed [SW-1:0] sample_w;
  logic [AW:0]          raddr_sum;
  logic [AW-1:0]        raddr;
  logic signed [SW-1:0] mem [WINDOW_SIZE];
  logic signed [SW-1:0] mem_q;
  logic signed [TW_W-1:0] cos_q;
  logic signed [TW_W-1:0] sin_q;

  // low bits of the field as two's complement, zero extended past 32 bits
  assign yaw_ext  = {32'b0, yaw_sample};
  assign sample_w = $signed(yaw_ext[SW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (cmd.take) begin
      wp <= (wp == AW'(WINDOW_SIZE - 1)) ? '0 : wp + 1'b1;
      if (fill != LN'(WINDOW_SIZE)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // oldest entry sits at the write pointer
  assign raddr_sum = {1'b0, wp} + {1'b0, n_sel};
  assign raddr     = (raddr_sum >= N_EXT) ? AW'(raddr_sum - N_EXT) : raddr_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem[wp] <= sample_w;
    end
    if (cmd.rd) begin
      mem_q <= mem[raddr];
      cos_q <= tw_cos[tw_idx];
      sin_q <= tw_sin[tw_idx];
    end
  end

  // magnitudes
  logic [SW-1:0]          abs_x;
  logic signed [SUMW-1:0] sum;
  logic [SUMW-1:0]        abs_sum;
  logic signed [ACW-1:0]  re;
  logic signed [ACW-1:0]  im;
  logic [ACW-1:0]         abs_re;
  logic [ACW-1:0]         abs_im;

  assign abs_x   = mem_q[SW-1] ? SW'(-mem_q) : SW'(mem_q);
  assign abs_sum = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
  assign abs_re  = re[ACW-1] ? ACW'(-re) : ACW'(re);
  assign abs_im  = im[ACW-1] ? ACW'(-im) : ACW'(im);

  // statistics and bin state
  logic [SQW-1:0]        sumsq;
  logic [CW-1:0]         lim;
  logic [CW-1:0]         spread;
  logic [CW-1:0]         pw;
  logic                  wig;
  logic                  fast;
  logic [LDW-1:0]        loud;
  logic signed [PRW-1:0] prod_re;
  logic signed [PRW-1:0] prod_im;

  // shared multiplier
  logic [CW-1:0] mul_a;
  logic [HW-1:0] mul_b;
  logic [CW-1:0] mul_p;
  logic          mul_fin;
  mul_op_t       op_q;
  logic [CW-1:0] tmp;

  always_comb begin
    case (cmd.mul_op)
      OP_SQX:  begin mul_a = CW'(abs_x);       mul_b = HW'(abs_x);       end
      OP_TN:   begin mul_a = CW'(WINDOW_SIZE); mul_b = HW'(thr);         end
      OP_TN2:  begin mul_a = tmp;              mul_b = tmp[HW-1:0];      end
      OP_SQN:  begin mul_a = CW'(sumsq);       mul_b = HW'(WINDOW_SIZE); end
      OP_SUM2: begin mul_a = CW'(abs_sum);     mul_b = HW'(abs_sum);     end
      OP_LW2:  begin mul_a = CW'(lw);          mul_b = HW'(lw);          end
      OP_LWN:  begin mul_a = tmp;              mul_b = HW'(NN);          end
      OP_LF2:  begin mul_a = CW'(lf);          mul_b = HW'(lf);          end
      OP_LFN:  begin mul_a = tmp;              mul_b = HW'(NN);          end
      OP_RE2:  begin mul_a = CW'(abs_re);      mul_b = HW'(abs_re);      end
      OP_IM2:  begin mul_a = CW'(abs_im);      mul_b = HW'(abs_im);      end
      default: begin mul_a = '0;               mul_b = '0;               end
    endcase
  end

  ywc_mul #(
    .A_W(CW),
    .B_W(HW)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .fin  (mul_fin),
    .p    (mul_p)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      op_q <= cmd.mul_op;
    end
    if (cmd.clr_stats) begin
      sum   <= '0;
      sumsq <= '0;
      loud  <= '0;
    end else begin
      if (cmd.acc_stat) begin
        sum <= sum + SUMW'(mem_q);
      end
      if (mul_fin && op_q == OP_SQX) begin
        sumsq <= sumsq + mul_p[SQW-1:0];
      end
      if (cmd.bin_cmp && ({pw[CW-3:0], 2'b00} > lim)) begin
        loud <= loud + 1'b1;
      end
    end
    if (mul_fin) begin
      case (op_q)
        OP_TN, OP_SQN, OP_LW2, OP_LF2: tmp    <= mul_p;
        OP_TN2:                        lim    <= mul_p;
        OP_SUM2:                       spread <= tmp - mul_p;
        OP_LWN:                        wig    <= spread > mul_p;
        OP_LFN:                        fast   <= spread > mul_p;
        OP_RE2:                        pw     <= mul_p;
        OP_IM2:                        pw     <= pw + mul_p;
        default: ;
      endcase
    end
    if (cmd.clr_bin) begin
      re <= '0;
      im <= '0;
    end else if (cmd.dft_acc) begin
      re <= re + ACW'(prod_re >>> TW_FRAC);
      im <= im + ACW'(prod_im >>> TW_FRAC);
    end
    if (cmd.dft_mul) begin
      prod_re <= PRW'(mem_q) * PRW'(cos_q);
      prod_im <= PRW'(mem_q) * PRW'(sin_q);
    end
  end

  // classification
  logic                   full;
  logic signed [MLW-1:0]  ml_n;
  logic                   small_mean;
  logic                   many_loud;
  cond_t                  cond;

  assign full       = (fill == LN'(WINDOW_SIZE));
  assign ml_n       = MLW'(ml) * N_S;
  assign small_mean = XCW'(sum) < XCW'(ml_n);
  assign many_loud  = LCW'(loud) > LCW'(bcl);

  always_comb begin
    if (!many_loud) begin
      cond = COND_NORMAL;
    end else if (small_mean && wig) begin
      cond = fast ? COND_FAST : COND_WIGGLE;
    end else begin
      cond = COND_ABNORMAL;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (full) begin
        condition   <= cond;
        window_full <= 1'b1;
        loud_bins   <= LOUD_W'(loud);
      end else begin
        condition   <= COND_NORMAL;
        window_full <= 1'b0;
        loud_bins   <= '0;
      end
    end
  end

  assign stat.full     = full;
  assign stat.mul_fin  = mul_fin;
  assign stat.res_free = !res_valid || res_ready;

endmodule

@@ sv/yaw_wiggle_classifier_core.sv @@
// yaw_wiggle_classifier_core: top level of the yaw wiggle classifier
// depends on ywc_pkg, ywc_in_if, ywc_out_if, ywc_ctrl, ywc_dp
//
// usage
// - sample channel: one signed q16.16 yaw sample per beat, pushed into a
//   sliding window of WINDOW_SIZE entries (oldest overwritten)
// - result channel: one beat per sample with condition, window_full and
//   loud_bins; until the window has been filled the beat reads normal / 0 / 0
// - config port: wr_en / wr_index / wr_data, write only while idle
// flow from the sample beat to result valid
// - one sample in flight; ready is high only while the sequencer is idle
// - window not yet full: the check state goes straight to the result load
// - full window: a statistics pass with one serial square per sample, the setup
//   product chain, then per bin a dft pass and two serial squares; the bin loop,
//   over the single window read port and the serial multiplier, dominates
// reset: sync active-high rst empties the window (fill count zero), restores
//   the register defaults and drops any pending result
// stalls: the result sits in an output register; the next sample is accepted
//   while it waits, and the following result holds until that register frees

module yaw_wiggle_classifier_core import ywc_pkg::*; #(
  parameter int unsigned WINDOW_SIZE  = WINDOW_SIZE_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ywc_in_if.sink                sample,
  ywc_out_if.source             result,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  localparam int unsigned AW = $clog2(WINDOW_SIZE);

  ywc_cmd_t      cmd;
  ywc_stat_t     stat;
  logic [AW-1:0] n_sel;
  logic [AW-1:0] tw_idx;

  // sequencer: window stats, setup products, then one bin at a time
  ywc_ctrl #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(sample.valid),
    .in_ready(sample.ready),
    .cmd     (cmd),
    .stat    (stat),
    .n_sel   (n_sel),
    .tw_idx  (tw_idx)
  );

  // window memory, arithmetic and the result register
  ywc_dp #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .n_sel      (n_sel),
    .tw_idx     (tw_idx),
    .yaw_sample (sample.yaw_sample),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .res_ready  (result.ready),
    .res_valid  (result.valid),
    .condition  (result.condition),
    .window_full(result.window_full),
    .loud_bins  (result.loud_bins)
  );

endmodule

@@ verif/ywc_classify_checker.sv @@
`timescale 1ns / 1ps
// ywc_classify_checker: watches the sample, result and register ports of the
// yaw wiggle classifier, predicts each result and compares it.
// depends on ywc_pkg, ywc_in_if, ywc_out_if

module ywc_classify_checker import ywc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  ywc_in_if                     smp,
  ywc_out_if                    res,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output int                    fails,
  output int                    pending
);

  localparam int NPT       = 64;
  localparam int EXP_DEPTH = 16;

  typedef longint unsigned u64_t;

  typedef struct packed {
    cond_t             condition;
    logic              window_full;
    logic [LOUD_W-1:0] loud_bins;
  } class_beat_t;

  // expected beats, written at the sample side, read at the result side
  class_beat_t exp_mem [EXP_DEPTH];
  int          wr_cnt;
  int          rd_cnt;

  logic signed [31:0] yaw_win [NPT];
  logic [5:0]         head;
  int                 filled;
  longint             cos_q15 [NPT];
  longint             sin_q15 [NPT];

  logic [31:0]        amp_thr;
  logic [5:0]         bin_lim;
  logic signed [31:0] mean_lim;
  logic [30:0]        std_wig;
  logic [30:0]        std_fst;

  function automatic longint round_q15(input longint v);
    longint a;
    a = ((v < 0) ? -v : v) + 16384;
    a = a >>> 15;
    return (v < 0) ? -a : a;
  endfunction

  initial begin
    longint unsigned ph, q, x, x2, ts, tc;
    longint s, c, rc, rs;
    for (int m = 0; m < NPT; m++) begin
      ph = (u64_t'(m) << 32) / NPT;
      q  = (ph >> 30) & 3;
      x  = ((ph & 64'h3FFF_FFFF) * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      s  = longint'(ts);
      c  = longint'(tc);
      for (int j = 1; j <= 8; j++) begin
        ts = ((ts * x2) >> 30) / u64_t'((2 * j) * (2 * j + 1));
        tc = ((tc * x2) >> 30) / u64_t'((2 * j - 1) * (2 * j));
        if (j % 2 == 1) begin
          s -= longint'(ts);
          c -= longint'(tc);
        end else begin
          s += longint'(ts);
          c += longint'(tc);
        end
      end
      case (q)
        0:       begin rc = c;  rs = s;  end
        1:       begin rc = -s; rs = c;  end
        2:       begin rc = -c; rs = -s; end
        default: begin rc = s;  rs = -c; end
      endcase
      cos_q15[m] = round_q15(rc);
      sin_q15[m] = round_q15(rs);
    end
  end

  // analysis of the full window, oldest sample first
  function automatic class_beat_t analyse_window();
    class_beat_t        r;
    longint             xs [NPT];
    longint             sum, re, im;
    logic signed [127:0] sumsq, lim, pw, re_w, im_w, spread, sw, sf;
    int                 loud, idx;
    logic [5:0]         p;
    sum   = 0;
    sumsq = 0;
    loud  = 0;
    for (int n = 0; n < NPT; n++) begin
      p     = head + 6'(n);
      xs[n] = yaw_win[p];
      sum  += xs[n];
      sumsq += 128'(xs[n] * xs[n]);
    end
    lim = 128'(amp_thr) * NPT;
    lim = lim * lim;
    for (int k = NPT / 2 + 1; k < NPT; k++) begin
      re = 0;
      im = 0;
      for (int n = 0; n < NPT; n++) begin
        idx = (n * k) % NPT;
        re += (xs[n] * cos_q15[idx]) >>> 15;
        im += (xs[n] * sin_q15[idx]) >>> 15;
      end
      re_w = re;
      im_w = im;
      pw   = 4 * (re_w * re_w + im_w * im_w);
      if (pw > lim) loud++;
    end
    r.window_full = 1'b1;
    r.loud_bins   = 6'(loud);
    r.condition   = COND_NORMAL;
    if (loud > bin_lim) begin
      re_w   = sum;
      spread = sumsq * NPT - re_w * re_w;
      sw     = 128'(std_wig);
      sf     = 128'(std_fst);
      if (sum < longint'(mean_lim) * NPT && spread > sw * sw * (NPT * (NPT - 1)))
        r.condition = (spread > sf * sf * (NPT * (NPT - 1))) ? COND_FAST : COND_WIGGLE;
      else
        r.condition = COND_ABNORMAL;
    end
    return r;
  endfunction

  assign pending = wr_cnt - rd_cnt;

  always @(posedge clk) begin
    class_beat_t e;
    int          nerr;
    nerr = 0;
    if (rst) begin
      head     = '0;
      filled   = 0;
      wr_cnt   = 0;
      rd_cnt   = 0;
      amp_thr  <= AMP_THR_RST;
      bin_lim  <= BIN_LIMIT_RST;
      mean_lim <= MEAN_LIMIT_RST;
      std_wig  <= STD_WIGGLE_RST;
      std_fst  <= STD_FAST_RST;
      fails    <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_AMP_THR:    amp_thr  <= wr_data;
          REG_BIN_LIMIT:  bin_lim  <= wr_data[5:0];
          REG_MEAN_LIMIT: mean_lim <= wr_data;
          REG_STD_WIGGLE: std_wig  <= wr_data[30:0];
          REG_STD_FAST:   std_fst  <= wr_data[30:0];
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        yaw_win[head] = smp.yaw_sample;
        head          = head + 6'd1;
        if (filled < NPT) filled = filled + 1;
        if (filled < NPT) e = '{COND_NORMAL, 1'b0, '0};
        else e = analyse_window();
        exp_mem[wr_cnt % EXP_DEPTH] = e;
        wr_cnt = wr_cnt + 1;
      end
      if (res.valid && res.ready) begin
        if (wr_cnt == rd_cnt) begin
          $error("result beat with nothing expected");
          nerr++;
        end else begin
          e      = exp_mem[rd_cnt % EXP_DEPTH];
          rd_cnt = rd_cnt + 1;
          if (res.condition !== e.condition) begin
            $error("condition: expected %0d actual %0d", e.condition, res.condition);
            nerr++;
          end
          if (res.window_full !== e.window_full) begin
            $error("window_full: expected %0d actual %0d", e.window_full, res.window_full);
            nerr++;
          end
          if (res.loud_bins !== e.loud_bins) begin
            $error("loud_bins: expected %0d actual %0d", e.loud_bins, res.loud_bins);
            nerr++;
          end
        end
      end
      fails <= fails + nerr;
    end
  end

endmodule

@@ verif/tb_yaw_wiggle_classifier_core.sv @@
`timescale 1ns / 1ps
// tb_yaw_wiggle_classifier_core: drives samples and register writes into the
// classifier, stalls the result side, and reports the verdict.
// depends on ywc_pkg, ywc_in_if, ywc_out_if, ywc_classify_checker, the core

module tb_yaw_wiggle_classifier_core;
  import ywc_pkg::*;

  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 56;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;
  int                    fails;
  int                    pending;

  // result-side stall control
  int                    stall_mode;
  int                    stall_span;

  // current sample shape: magnitude exponent and dc offset
  int                    mag_exp;
  logic signed [31:0]    dc_offset;

  ywc_in_if  sample_ch ();
  ywc_out_if result_ch ();

  yaw_wiggle_classifier_core DUT (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample_ch.sink),
    .result   (result_ch.source),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  ywc_classify_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .smp      (sample_ch),
    .res      (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .fails    (fails),
    .pending  (pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern: spans of always-ready, light and heavy stalls
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_mode      <= 0;
      stall_span      <= 0;
    end else begin
      if (stall_span == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_span <= $urandom_range(20, 300);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        0:       result_ch.ready <= 1'b1;
        1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
        default: result_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // one sample beat; valid stays up when the next beat follows directly
  task automatic push_sample(input logic [31:0] yaw, input bit burst_end);
    int gap;
    sample_ch.valid      <= 1'b1;
    sample_ch.yaw_sample <= yaw;
    do @(posedge clk); while (!sample_ch.ready);
    if (burst_end) begin
      sample_ch.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  // random sample of the current shape, wraps at 32 bits
  function automatic logic [31:0] shaped_yaw();
    logic signed [31:0] v;
    if (mag_exp >= 31) v = $urandom;
    else v = $signed($urandom_range(0, (32'd1 << (mag_exp + 1)) - 1)) - (32'sd1 << mag_exp);
    return v + dc_offset;
  endfunction

  // write all five registers back to back, plus one write to an unused index;
  // upper bits beyond each register width carry random junk
  task automatic write_regs(input logic [31:0] thr, input logic [5:0] lim,
                            input logic [31:0] mean, input logic [30:0] wig,
                            input logic [30:0] fst);
    logic [31:0] vals [5];
    logic [CFG_IDX_W-1:0] idxs [5];
    vals[0] = thr;
    vals[1] = ($urandom & ~32'h3F) | lim;
    vals[2] = mean;
    vals[3] = {1'($urandom), wig};
    vals[4] = {1'($urandom), fst};
    idxs[0] = REG_AMP_THR;
    idxs[1] = REG_BIN_LIMIT;
    idxs[2] = REG_MEAN_LIMIT;
    idxs[3] = REG_STD_WIGGLE;
    idxs[4] = REG_STD_FAST;
    for (int i = 0; i < 5; i++) begin
      wr_en    <= 1'b1;
      wr_index <= idxs[i];
      wr_data  <= vals[i];
      @(posedge clk);
    end
    // index past the register file must be ignored
    wr_index <= CFG_IDX_W'($urandom_range(REG_STD_FAST + 1, 7));
    wr_data  <= $urandom;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // pick a setting per phase: edges on early phases, then random around the
  // interesting region so all four classes show up
  task automatic new_setting(input int ph);
    logic [31:0] thr;
    logic [5:0]  lim;
    logic [31:0] mean;
    logic [30:0] wig;
    logic [30:0] fst;
    case (ph)
      0: begin thr = '0; lim = 6'd0; mean = 32'h7FFF_FFFF; wig = '0; fst = '0; end
      1: begin thr = '1; lim = 6'd32; mean = 32'h8000_0000; wig = '1; fst = '1; end
      2: begin thr = 32'd16384; lim = 6'd32; mean = 32'h7FFF_FFFF; wig = '0; fst = '1; end
      3: begin thr = 32'd8192; lim = 6'd0; mean = 32'h8000_0000; wig = 31'd65536; fst = '0; end
      default: begin
        thr  = $urandom_range(32'd4096, 32'd262144);
        lim  = 6'($urandom_range(0, 32));
        mean = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        wig  = 31'($urandom_range(32'd32768, 32'd524288));
        fst  = 31'(wig + $urandom_range(0, 32'd524288));
      end
    endcase
    write_regs(thr, lim, mean, wig, fst);
  endtask

  // fixed run limit, far above the slowest legal run
  initial begin
    #400_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int          blen;
    logic [31:0] edge_vals [8];
    sample_ch.valid      <= 1'b0;
    sample_ch.yaw_sample <= '0;
    wr_en                <= 1'b0;
    wr_index             <= '0;
    wr_data              <= '0;
    rst                  <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes while the window fills, reset register values
    edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA};
    for (int i = 0; i < 24; i++)
      push_sample(edge_vals[i % 8], (i % 5) == 4);
    sample_ch.valid <= 1'b0;
    @(posedge clk);

    // random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      wait (pending == 0);
      @(posedge clk);
      new_setting(ph);
      blen = 0;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        // new shape now and then: mostly mid-scale noise, sometimes full range
        if (i % 8 == 0) begin
          mag_exp   = ($urandom_range(0, 7) == 0) ? 31 : $urandom_range(12, 22);
          dc_offset = ($urandom_range(0, 2) == 0) ?
                      $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000 : '0;
        end
        if (blen == 0) blen = $urandom_range(1, 8);
        blen--;
        push_sample(shaped_yaw(), blen == 0 || i == PHASE_BEATS - 1);
      end
    end

    // drain
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
